### design/burgers_two_step_stencil_assert.svh
// Assertion macros for the stencil RTL.
// Included by the stencil module to check its own control logic.
`ifndef BURGERS_TWO_STEP_STENCIL_ASSERT_SVH
`define BURGERS_TWO_STEP_STENCIL_ASSERT_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BTS_ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
    else $error(msg);
`else
`define BTS_ASSERT(label, clk, rst_n, prop, msg)
`define BTS_ASSERT_KNOWN(label, clk, rst_n, sig, msg)
`endif
`endif

### design/bts_pkg.sv
// Types and constants for the two-step stencil block.
// No dependencies.
package bts_pkg;

  localparam int unsigned RegWidth = 31;
  localparam int unsigned ValWidth = 32;
  localparam int unsigned NumWidth = 11;
  localparam int unsigned IdxWidth = 3;

  // Register indexes.
  localparam logic [IdxWidth-1:0] RegStepOverSpacing  = 3'd0;
  localparam logic [IdxWidth-1:0] RegTimeStep         = 3'd1;
  localparam logic [IdxWidth-1:0] RegSourceFirstCell  = 3'd2;
  localparam logic [IdxWidth-1:0] RegSourceRatio      = 3'd3;
  localparam logic [IdxWidth-1:0] RegHalfUpRatio      = 3'd4;
  localparam logic [IdxWidth-1:0] RegHalfDownRatio    = 3'd5;

  typedef logic signed [ValWidth-1:0] val_t;

  typedef struct packed {
    val_t                new_value;
    logic [NumWidth-1:0] cell_number;
    logic                end_of_sweep;
  } out_beat_t;

  typedef struct packed {
    val_t cell_value;
    logic first_cell;
    logic last_cell;
  } in_beat_t;

  // Sequencer states; each compute step is one multiply or one saturating sum.
  typedef enum logic [4:0] {
    StIdle,
    StFluxR, StFluxC, StFluxL,
    StSrcUp, StSrcDn,
    StUpK, StUpS, StUpSum,
    StDnK, StDnS, StDnSum,
    StFluxUp, StFluxDn,
    StResK, StResS, StResSum,
    StNextSrc,
    StOut0, StOut1
  } state_e;

  // Saturate a wide signed value to 32 bits.
  function automatic val_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### design/bts_if.sv
// Valid/ready channel interface for the stencil block.
// Depends on nothing; payload type is a parameter.
interface bts_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/bts_mul.sv
// Shared rounding multiplier: 33x33 signed product, rounded shift, saturation.
// Depends on bts_pkg.
module bts_mul import bts_pkg::*; #(
  parameter int unsigned FractionBits = 24
) (
  input  logic signed [ValWidth:0] a_i,
  input  logic signed [ValWidth:0] b_i,
  input  logic                     half_i,
  output val_t                     p_o
);
  logic signed [2*ValWidth+1:0] prod;
  logic signed [2*ValWidth+1:0] rnd;
  logic signed [2*ValWidth+1:0] sh;

  // Add half an LSB at the scaled position, then arithmetic shift (floor).
  always_comb begin
    prod = a_i * b_i;
    if (half_i) begin
      rnd = prod + ((2*ValWidth+2)'(1) <<< FractionBits);
      sh  = rnd >>> (FractionBits + 1);
    end else begin
      rnd = prod + ((2*ValWidth+2)'(1) <<< (FractionBits - 1));
      sh  = rnd >>> FractionBits;
    end
    p_o = sat32(sh[65:0]);
  end
endmodule

### design/burgers_two_step_stencil.sv
// Streams one time step of a 1-D Burgers grid with a two-step Lax-Wendroff
// update. A small sequencer runs each interior cell through fourteen
// multiplications on one shared multiplier and three saturating sums, one step
// per cycle, then presents one result beat (two on the ghost cell). The input
// is not ready while the sequencer runs or a result beat waits, so a new input
// beat is not taken until the current cell is finished and its result beats
// are taken. Cell 0 and a ghost right after cell 0 present a beat at once;
// cell 1 and ignored beats only update state and leave the input ready. The
// multiplier step count sets the rate. Configure only while the block is idle.
`include "burgers_two_step_stencil_assert.svh"
module burgers_two_step_stencil import bts_pkg::*; #(
  parameter int unsigned MAX_CELLS     = 1024,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_index_i,
  input  logic [RegWidth-1:0] cfg_data_i,
  bts_if.sink                 in_if,
  bts_if.source               out_if
);
  localparam int unsigned CntWidth = $clog2(MAX_CELLS + 1);

  // Configuration registers.
  logic [RegWidth-1:0] r_q, t_q, s0_q, ratio_q, up_q, dn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0; t_q <= '0; s0_q <= '0;
      ratio_q <= RegWidth'(1) << FRACTION_BITS;
      up_q    <= RegWidth'(1) << FRACTION_BITS;
      dn_q    <= RegWidth'(1) << FRACTION_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegStepOverSpacing: r_q     <= cfg_data_i;
        RegTimeStep:        t_q     <= cfg_data_i;
        RegSourceFirstCell: s0_q    <= cfg_data_i;
        RegSourceRatio:     ratio_q <= cfg_data_i;
        RegHalfUpRatio:     up_q    <= cfg_data_i;
        RegHalfDownRatio:   dn_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  val_t left_q, left_d, ctr_q, ctr_d, right_q, right_d, src_q, src_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic ghost_q, ghost_d;
  // Scratch: fluxes, source terms, face terms, result.
  val_t fr_q, fr_d, fc_q, fc_d, fl_q, fl_d, su_q, su_d, sd_q, sd_d;
  val_t k_q, k_d, s_q, s_d, upv_q, upv_d, dnv_q, dnv_d, res_q, res_d;
  out_beat_t ob_q, ob_d;
  logic ov_q, ov_d;

  // Shared multiplier operands.
  logic signed [ValWidth:0] ma, mb;
  logic                     mhalf;
  val_t                     mp;
  bts_mul #(.FractionBits(FRACTION_BITS)) u_mul (
    .a_i(ma), .b_i(mb), .half_i(mhalf), .p_o(mp)
  );

  function automatic logic signed [ValWidth:0] sx(input val_t v);
    return {v[ValWidth-1], v};
  endfunction
  function automatic logic signed [ValWidth:0] ux(input logic [RegWidth-1:0] v);
    return {2'b00, v};
  endfunction

  logic accept;
  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle) && !ov_q;
  assign out_if.valid   = ov_q;
  assign out_if.payload = ob_q;

  always_comb begin
    state_d = state_q; left_d = left_q; ctr_d = ctr_q; right_d = right_q;
    src_d = src_q; cnt_d = cnt_q; ghost_d = ghost_q;
    fr_d = fr_q; fc_d = fc_q; fl_d = fl_q; su_d = su_q; sd_d = sd_q;
    k_d = k_q; s_d = s_q; upv_d = upv_q; dnv_d = dnv_q; res_d = res_q;
    ob_d = ob_q; ov_d = ov_q;
    ma = '0; mb = '0; mhalf = 1'b0;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_if.payload.first_cell) begin
            ob_d = '{new_value: in_if.payload.cell_value, cell_number: '0,
                     end_of_sweep: 1'b0};
            ov_d = 1'b1;
            left_d = '0; ctr_d = in_if.payload.cell_value;
            src_d = val_t'({1'b0, s0_q}); cnt_d = CntWidth'(1);
          end else if (cnt_q != '0) begin
            ghost_d = in_if.payload.last_cell || (cnt_q >= CntWidth'(MAX_CELLS));
            if (cnt_q == CntWidth'(1)) begin
              if (ghost_d) begin
                ob_d = '{new_value: ctr_q, cell_number: NumWidth'(1),
                         end_of_sweep: 1'b1};
                ov_d = 1'b1; cnt_d = '0;
              end else begin
                left_d = ctr_q; ctr_d = in_if.payload.cell_value;
                cnt_d = CntWidth'(2);
              end
            end else begin
              right_d = in_if.payload.cell_value;
              state_d = StFluxR;
            end
          end
        end
      end
      StFluxR: begin ma = sx(right_q); mb = sx(right_q); mhalf = 1'b1; fr_d = mp;
        state_d = StFluxC; end
      StFluxC: begin ma = sx(ctr_q); mb = sx(ctr_q); mhalf = 1'b1; fc_d = mp;
        state_d = StFluxL; end
      StFluxL: begin ma = sx(left_q); mb = sx(left_q); mhalf = 1'b1; fl_d = mp;
        state_d = StSrcUp; end
      StSrcUp: begin ma = sx(src_q); mb = ux(up_q); su_d = mp; state_d = StSrcDn; end
      StSrcDn: begin ma = sx(src_q); mb = ux(dn_q); sd_d = mp; state_d = StUpK; end
      StUpK: begin
        ma = ux(r_q); mb = sx(sat32(66'(fr_q) - 66'(fc_q))); mhalf = 1'b1; k_d = mp;
        state_d = StUpS;
      end
      StUpS: begin ma = ux(t_q); mb = sx(su_q); mhalf = 1'b1; s_d = mp;
        state_d = StUpSum; end
      StUpSum: begin
        upv_d = sat32(((66'(ctr_q) + 66'(right_q) + 66'sd1) >>> 1) - 66'(k_q)
                      + 66'(s_q));
        state_d = StDnK;
      end
      StDnK: begin
        ma = ux(r_q); mb = sx(sat32(66'(fc_q) - 66'(fl_q))); mhalf = 1'b1; k_d = mp;
        state_d = StDnS;
      end
      StDnS: begin ma = ux(t_q); mb = sx(sd_q); mhalf = 1'b1; s_d = mp;
        state_d = StDnSum; end
      StDnSum: begin
        dnv_d = sat32(((66'(left_q) + 66'(ctr_q) + 66'sd1) >>> 1) - 66'(k_q)
                      + 66'(s_q));
        state_d = StFluxUp;
      end
      StFluxUp: begin ma = sx(upv_q); mb = sx(upv_q); mhalf = 1'b1; fr_d = mp;
        state_d = StFluxDn; end
      StFluxDn: begin ma = sx(dnv_q); mb = sx(dnv_q); mhalf = 1'b1; fl_d = mp;
        state_d = StResK; end
      StResK: begin ma = ux(r_q); mb = sx(sat32(66'(fr_q) - 66'(fl_q))); k_d = mp;
        state_d = StResS; end
      StResS: begin ma = ux(t_q); mb = sx(src_q); s_d = mp; state_d = StResSum; end
      StResSum: begin
        res_d = sat32(66'(ctr_q) - 66'(k_q) + 66'(s_q));
        state_d = StNextSrc;
      end
      StNextSrc: begin
        ma = sx(src_q); mb = ux(ratio_q);
        if (!ghost_q) begin
          src_d = mp; left_d = ctr_q; ctr_d = right_q;
        end
        state_d = StOut0;
      end
      StOut0: begin
        if (!ov_q) begin
          ob_d = '{new_value: res_q, cell_number: NumWidth'(cnt_q - CntWidth'(1)),
                   end_of_sweep: 1'b0};
          ov_d = 1'b1;
          if (ghost_q) state_d = StOut1;
          else begin
            cnt_d = cnt_q + CntWidth'(1); state_d = StIdle;
          end
        end
      end
      StOut1: begin
        if (!ov_d) begin
          ob_d = '{new_value: res_q, cell_number: NumWidth'(cnt_q), end_of_sweep: 1'b1};
          ov_d = 1'b1; cnt_d = '0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; ov_q <= 1'b0;
      left_q <= '0; ctr_q <= '0; src_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ov_q <= ov_d;
      left_q <= left_d; ctr_q <= ctr_d; src_q <= src_d;
    end
  end

  // Datapath scratch.
  always_ff @(posedge clk_i) begin
    right_q <= right_d; ghost_q <= ghost_d; fr_q <= fr_d; fc_q <= fc_d; fl_q <= fl_d;
    su_q <= su_d; sd_q <= sd_d; k_q <= k_d; s_q <= s_d; upv_q <= upv_d;
    dnv_q <= dnv_d; res_q <= res_d; ob_q <= ob_d;
  end

  `BTS_ASSERT(a_busy_not_ready, clk_i, rst_ni, (state_q != StIdle) |-> !in_if.ready, "ready while busy")
  `BTS_ASSERT(a_hold_beat, clk_i, rst_ni, (ov_q && !out_if.ready) |=> (ov_q && $stable(ob_q)), "beat lost")
  `BTS_ASSERT(a_ghost_end, clk_i, rst_ni, (state_q == StOut1 && state_d == StIdle) |=> (cnt_q == '0), "no end")
  `BTS_ASSERT_KNOWN(a_valid_known, clk_i, rst_ni, out_if.valid, "valid unknown")
  `BTS_ASSERT_KNOWN(a_ready_known, clk_i, rst_ni, in_if.ready, "ready unknown")
endmodule
